// ----- hdl/sfcp_pkg.sv -----
// Shared types and constants for the status frame CRC-4 packer.
// No dependencies; imported by every module of the block.
package sfcp_pkg;

  localparam int FRAME_LEN    = 16;
  localparam int SAMPLE_COUNT = 7;
  localparam int BYTE_IDX_W   = 4;

  localparam logic [BYTE_IDX_W-1:0] TH_IDX   = BYTE_IDX_W'(14);
  localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(FRAME_LEN - 1);

  // x^4+x+1 nibble table
  localparam logic [15:0][3:0] CRC_TAB = {
    4'd2, 4'd1, 4'd4, 4'd7, 4'd14, 4'd13, 4'd8, 4'd11,
    4'd9, 4'd10, 4'd15, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0
  };

  typedef struct packed {
    logic [15:0] analog_a1;
    logic [15:0] analog_a2;
    logic [15:0] analog_a3;
    logic [15:0] analog_a4;
    logic [15:0] analog_a5;
    logic [15:0] analog_a6;
    logic [15:0] battery_level;
    logic [3:0]  port_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_item_t;

  // One queued frame: sample[0] is analog_a1, sample[6] is battery_level
  typedef struct packed {
    logic [SAMPLE_COUNT-1:0][15:0] sample;
    logic [3:0]                    port_bits;
    logic [7:0]                    threshold_code;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [3:0] crc_step(input logic [3:0] crc, input logic [3:0] nib);
    crc_step = CRC_TAB[crc] ^ nib;
  endfunction

  function automatic logic [3:0] crc_byte(input logic [3:0] crc, input logic [7:0] b);
    crc_byte = crc_step(crc_step(crc, b[7:4]), b[3:0]);
  endfunction

endpackage

// ----- hdl/status_frame_crc4_packer.sv -----
// Status frame packer: one request in, a 16-byte frame with CRC-4 out.
// Instantiates sfcp_front, sfcp_queue and sfcp_back; depends on sfcp_pkg.
//
// A request is taken on a clock edge with start high and busy low. Its frame
// leaves one byte per cycle on out_item with out_strobe high, low byte of each
// sample first, threshold code in byte 14, port bits and CRC-4 in byte 15
// (last_byte set). A request passes the queue, the record register and the
// output register before its first byte appears; frames follow each other
// with no gap while the next request is queued. The receiver cannot hold
// bytes off. Sustained rate is set by the one-byte-per-cycle serializer;
// up to QUEUE_DEPTH requests wait in the queue in front of it, and busy is
// high while that queue is full. The threshold code is written through
// cfg_we/cfg_wdata and sampled when a request is taken.
module status_frame_crc4_packer
  import sfcp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_strobe,
  output out_item_t  out_item
);

  q_stat_t    q_stat;
  logic       push;
  logic       pop;
  frame_rec_t push_rec;
  frame_rec_t head_rec;

  sfcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_rec  (push_rec)
  );

  sfcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  sfcp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ----- hdl/sfcp_front.sv -----
// Request front end: threshold register, start/busy handshake, frame record build.
// Depends on sfcp_pkg.
module sfcp_front
  import sfcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  input  q_stat_t    q_stat,
  output logic       push,
  output frame_rec_t push_rec
);

  logic [7:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  always_comb begin
    push_rec.sample[0]      = in_item.analog_a1;
    push_rec.sample[1]      = in_item.analog_a2;
    push_rec.sample[2]      = in_item.analog_a3;
    push_rec.sample[3]      = in_item.analog_a4;
    push_rec.sample[4]      = in_item.analog_a5;
    push_rec.sample[5]      = in_item.analog_a6;
    push_rec.sample[6]      = in_item.battery_level;
    push_rec.port_bits      = in_item.port_bits;
    push_rec.threshold_code = thr_r;
  end

endmodule

// ----- hdl/sfcp_queue.sv -----
// Frame record queue between the front end and the serializer.
// Depends on sfcp_pkg. DEPTH from 2 up.
module sfcp_queue
  import sfcp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t push_rec,
  input  logic       pop,
  output frame_rec_t head_rec,
  output q_stat_t    q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t        slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign head_rec     = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

endmodule

// ----- hdl/sfcp_back.sv -----
// Frame serializer: emits 16 bytes per record, running CRC-4 one byte per cycle.
// Depends on sfcp_pkg.
module sfcp_back
  import sfcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  frame_rec_t head_rec,
  output logic       pop,
  output logic       out_strobe,
  output out_item_t  out_item
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } state_t;

  state_t                state_r;
  frame_rec_t            rec_r;
  logic [BYTE_IDX_W-1:0] idx_r;
  logic [3:0]            crc_r;
  logic [3:0]            crc_nxt;
  logic [15:0]           word;
  logic [7:0]            byte_nxt;
  logic                  out_strobe_r;
  out_item_t             out_item_r;

  // next record loads on the last byte of the current one, so frames abut
  assign pop = !q_stat.empty && ((state_r == S_IDLE) || (idx_r == LAST_IDX));

  always_comb begin
    word = '0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (idx_r[BYTE_IDX_W-1:1] == (BYTE_IDX_W-1)'(i)) word = rec_r.sample[i];
    end
  end

  always_comb begin
    priority if (idx_r == LAST_IDX) begin
      byte_nxt = {rec_r.port_bits,
                  CRC_TAB[crc_step(crc_r, rec_r.port_bits)]};
    end else if (idx_r == TH_IDX) begin
      byte_nxt = rec_r.threshold_code;
    end else begin
      byte_nxt = idx_r[0] ? word[15:8] : word[7:0];
    end
    crc_nxt = crc_byte(crc_r, byte_nxt);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= head_rec;
    end
    if (pop) begin
      crc_r <= '0;
    end else if (state_r == S_SEND) begin
      crc_r <= crc_nxt;
    end
    out_item_r.frame_byte <= byte_nxt;
    out_item_r.last_byte  <= (idx_r == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == S_SEND);
      if (pop) begin
        state_r <= S_SEND;
        idx_r   <= '0;
      end else begin
        unique case (state_r)
          S_IDLE: begin
            state_r <= S_IDLE;
          end
          S_SEND: begin
            idx_r <= idx_r + BYTE_IDX_W'(1);
            if (idx_r == LAST_IDX) state_r <= S_IDLE;
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("serializer state not one-hot");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND && idx_r == LAST_IDX) |=> (out_strobe && out_item.last_byte))
    else $error("sixteenth byte not flagged as last");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last_byte) |=> out_strobe)
    else $error("gap inside a frame");

endmodule
